@@ design/pdb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_pkg: shared types and constants of the pair distance binner
// Operation codes, configuration register indexes, fixed field widths,
// register reset values and the one-hot sequencer states.
// ----------------------------------------------------------------------------
package pdb_pkg;

  // Fixed field widths
  localparam int EDGE_W  = 52;
  localparam int TRACK_W = 20;
  localparam int FRAME_W = 16;
  localparam int LEN_W   = 17;
  localparam int CFG_W   = 16;
  localparam int COUNT_W = 17;
  localparam int BINO_W  = 3;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PAIR = 1'b1;

  // Configuration register indexes
  localparam logic CFG_MIN_LEN   = 1'b0;
  localparam logic CFG_MAX_PAIRS = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] MIN_LEN_RST   = 16'd100;
  localparam logic [CFG_W-1:0] MAX_PAIRS_RST = 16'd50000;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SQUARE = 5'b00010,
    ST_CHECK  = 5'b00100,
    ST_WALK   = 5'b01000,
    ST_FLUSH  = 5'b10000
  } state_e;

endpackage

@@ design/pair_distance_binner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_distance_binner: sorts particle pairs into squared-distance bins
// One shared squaring multiplier forms the squared distance, then a walk
// over the bins compares it with the stored edges, one bin per cycle.
// ----------------------------------------------------------------------------
//
//  channel   handshake                      payload
//  -------   -----------------------------  ---------------------------------
//  item      start high and busy low         op_i, bin_select_i, edges, deltas,
//                                            tracks, frame, end frames
//  result    result_valid_o, one cycle each  bin_index_o, out_track_a_o, ...
//  config    cfg_we_i                        cfg_idx_i, cfg_wdata_i
//
//  A load word takes effect at once and leaves busy low.
//  A pair word runs squaring, a range check that ends it when the distance lies past the
//  last bin, a walk of up to NUM_BINS bins (one edge memory read each) and a flush.
//  A record is held until the next recorded bin or the flush, then shows in the cycle after.
//  Reset clears the sequencer, counts (per-bin valid bits) and full flags;
//  edges hold garbage until loaded. Results cannot be stalled.

module pair_distance_binner #(
  parameter int NUM_BINS   = 8,
  parameter int COORD_BITS = 25
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              op_i,
  input  logic [pdb_pkg::BINO_W-1:0]        bin_select_i,
  input  logic [pdb_pkg::EDGE_W-1:0]        edge_low_sq_i,
  input  logic [pdb_pkg::EDGE_W-1:0]        edge_high_sq_i,
  input  logic signed [COORD_BITS-1:0]      delta_x_i,
  input  logic signed [COORD_BITS-1:0]      delta_y_i,
  input  logic signed [COORD_BITS-1:0]      delta_z_i,
  input  logic [pdb_pkg::TRACK_W-1:0]       track_a_i,
  input  logic [pdb_pkg::TRACK_W-1:0]       track_b_i,
  input  logic [pdb_pkg::FRAME_W-1:0]       frame_number_i,
  input  logic [pdb_pkg::FRAME_W-1:0]       end_frame_a_i,
  input  logic [pdb_pkg::FRAME_W-1:0]       end_frame_b_i,
  // result channel
  output logic                              result_valid_o,
  output logic [pdb_pkg::BINO_W-1:0]        bin_index_o,
  output logic [pdb_pkg::TRACK_W-1:0]       out_track_a_o,
  output logic [pdb_pkg::TRACK_W-1:0]       out_track_b_o,
  output logic [pdb_pkg::FRAME_W-1:0]       out_frame_o,
  output logic [pdb_pkg::LEN_W-1:0]         pair_length_o,
  output logic                              last_of_run_o,
  // configuration port
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [pdb_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import pdb_pkg::*;

  localparam int IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int DIST_W = 2 * COORD_BITS;
  localparam int CMP_W  = (DIST_W > EDGE_W) ? DIST_W : EDGE_W;
  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);

  // Control state
  state_e               state_q, state_d;
  logic [1:0]           sq_cnt_q;
  logic [IDX_W-1:0]     walk_q;
  logic                 pend_vld_q;
  logic                 out_vld_q;
  logic [CFG_W-1:0]     min_len_q;
  logic [CFG_W-1:0]     max_pairs_q;
  logic [NUM_BINS-1:0]  cnt_vld_q;
  logic [NUM_BINS-1:0]  full_q;

  // Payload state
  logic [COORD_BITS-1:0] dx_q, dy_q, dz_q;
  logic [TRACK_W-1:0]    track_a_q, track_b_q;
  logic [FRAME_W-1:0]    frame_q;
  logic signed [LEN_W:0] len_q;
  logic [DIST_W-1:0]     prod_q, dist_q;
  logic [IDX_W-1:0]      pend_bin_q;
  logic [BINO_W-1:0]     out_bin_q;
  logic                  out_last_q;

  // Bin memories
  logic [EDGE_W-1:0]  lo_mem [NUM_BINS];
  logic [EDGE_W-1:0]  hi_mem [NUM_BINS];
  logic [COUNT_W-1:0] cnt_mem [NUM_BINS];
  logic [EDGE_W-1:0]  lo_rd_q, hi_rd_q;
  logic [COUNT_W-1:0] cnt_rd_q;
  logic [IDX_W-1:0]   rd_addr;

  logic accept, accept_pair, load_hit;
  logic [FRAME_W-1:0]    end_min;
  logic signed [LEN_W:0] len_d;

  assign accept      = start && !busy;
  assign accept_pair = accept && (op_i == OP_PAIR);
  assign load_hit    = accept && (op_i == OP_LOAD) && (32'(bin_select_i) < NUM_BINS);

  // Pair length: smaller end frame minus frame plus one
  assign end_min = (end_frame_a_i < end_frame_b_i) ? end_frame_a_i : end_frame_b_i;
  assign len_d   = $signed({2'b00, end_min}) - $signed({2'b00, frame_number_i})
                   + (LEN_W+1)'(1);

  // Shared squaring unit: magnitude of one delta times itself
  logic [COORD_BITS-1:0] sq_sel, mag;
  logic [DIST_W-1:0]     prod;

  always_comb begin
    unique case (sq_cnt_q)
      2'd0:    sq_sel = dx_q;
      2'd1:    sq_sel = dy_q;
      default: sq_sel = dz_q;
    endcase
    mag  = sq_sel[COORD_BITS-1] ? (~sq_sel + COORD_BITS'(1)) : sq_sel;
    prod = {{COORD_BITS{1'b0}}, mag} * {{COORD_BITS{1'b0}}, mag};
  end

  // Bin evaluation for the walk step
  logic [CMP_W-1:0]   dist_c, lo_c, hi_c;
  logic [COUNT_W-1:0] cnt_cur, cnt_inc;
  logic               len_ok, stop, hit, beyond, bin_full;

  always_comb begin
    dist_c   = CMP_W'(dist_q);
    lo_c     = CMP_W'(lo_rd_q);
    hi_c     = CMP_W'(hi_rd_q);
    beyond   = dist_c > hi_c;
    len_ok   = len_q > $signed({2'b00, min_len_q});
    stop     = full_q[walk_q] || (dist_c < lo_c);
    hit      = !stop && !beyond && len_ok;
    cnt_cur  = cnt_vld_q[walk_q] ? cnt_rd_q : '0;
    cnt_inc  = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_W'(1);
    bin_full = cnt_inc > {1'b0, max_pairs_q};
  end

  // Read address: last bin for the range check, then one bin ahead of the walk
  always_comb begin
    unique case (state_q)
      ST_CHECK: rd_addr = '0;
      ST_WALK:  rd_addr = walk_q + IDX_W'(1);
      default:  rd_addr = LAST_BIN;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept_pair) state_d = ST_SQUARE;
      ST_SQUARE: if (sq_cnt_q == 2'd3) state_d = ST_CHECK;
      ST_CHECK:  state_d = beyond ? ST_IDLE : ST_WALK;
      ST_WALK:   if (stop || walk_q == LAST_BIN) state_d = ST_FLUSH;
      ST_FLUSH:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Emit the held record when a newer one arrives or at the flush
  logic emit, emit_last;
  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    if (state_q == ST_WALK && hit && pend_vld_q) begin
      emit = 1'b1;
    end else if (state_q == ST_FLUSH && pend_vld_q) begin
      emit      = 1'b1;
      emit_last = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sq_cnt_q    <= '0;
      walk_q      <= '0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      min_len_q   <= MIN_LEN_RST;
      max_pairs_q <= MAX_PAIRS_RST;
      cnt_vld_q   <= '0;
      full_q      <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= emit;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIN_LEN:   min_len_q   <= cfg_wdata_i;
          CFG_MAX_PAIRS: max_pairs_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept_pair) begin
        sq_cnt_q   <= '0;
        walk_q     <= '0;
        pend_vld_q <= 1'b0;
      end
      if (state_q == ST_SQUARE) sq_cnt_q <= sq_cnt_q + 2'd1;
      if (state_q == ST_WALK) begin
        walk_q <= walk_q + IDX_W'(1);
        if (hit) begin
          pend_vld_q        <= 1'b1;
          cnt_vld_q[walk_q] <= 1'b1;
          if (bin_full) full_q[walk_q] <= 1'b1;
        end
      end
      if (state_q == ST_FLUSH) pend_vld_q <= 1'b0;
    end
  end

  // Payload registers: captured word, squared distance, held record
  always_ff @(posedge clk_i) begin
    if (accept_pair) begin
      dx_q      <= delta_x_i;
      dy_q      <= delta_y_i;
      dz_q      <= delta_z_i;
      track_a_q <= track_a_i;
      track_b_q <= track_b_i;
      frame_q   <= frame_number_i;
      len_q     <= len_d;
      dist_q    <= '0;
    end
    if (state_q == ST_SQUARE) begin
      prod_q <= prod;
      if (sq_cnt_q != 2'd0) dist_q <= dist_q + prod_q;
    end
    if (state_q == ST_WALK && hit) pend_bin_q <= walk_q;
    if (emit) begin
      out_bin_q  <= BINO_W'(pend_bin_q);
      out_last_q <= emit_last;
    end
  end

  // Edge and count memories
  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      lo_mem[IDX_W'(bin_select_i)] <= edge_low_sq_i;
      hi_mem[IDX_W'(bin_select_i)] <= edge_high_sq_i;
    end
    if (state_q == ST_WALK && hit) cnt_mem[walk_q] <= cnt_inc;
    lo_rd_q  <= lo_mem[rd_addr];
    hi_rd_q  <= hi_mem[rd_addr];
    cnt_rd_q <= cnt_mem[rd_addr];
  end

  // Outputs
  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = out_vld_q;
  assign bin_index_o    = out_bin_q;
  assign out_track_a_o  = track_a_q;
  assign out_track_b_o  = track_b_q;
  assign out_frame_o    = frame_q;
  assign pair_length_o  = len_q[LEN_W-1:0];
  assign last_of_run_o  = out_last_q;

endmodule

@@ design/pdb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_checker: port-level checks of the pair distance binner
// Watches the item handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module pdb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       op_i,
  input logic                       result_valid_o,
  input logic                       last_of_run_o,
  input logic [pdb_pkg::LEN_W-1:0]  pair_length_o
);
  import pdb_pkg::*;

  // A record only follows a cycle of pair work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result word without preceding pair work");

  // An accepted pair word occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OP_PAIR) |=> busy)
    else $error("pair word accepted but block not busy");

  // A load word leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OP_LOAD) |=> !busy)
    else $error("load word made the block busy");

  // No record directly follows the final record of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_of_run_o) |=> !result_valid_o)
    else $error("result word right after the final record");

  // Recorded pairs have a positive length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (pair_length_o != '0))
    else $error("record with zero pair length");

endmodule

bind pair_distance_binner pdb_checker u_pdb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .op_i           (op_i),
  .result_valid_o (result_valid_o),
  .last_of_run_o  (last_of_run_o),
  .pair_length_o  (pair_length_o)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the pair distance binner
// Loads bin edges and sends particle pair words, keeps its own copy of the
// edges, bin counts and full flags, and compares each record the block emits
// against the predicted one. Register settings change between phases, and
// sender gaps vary from phase to phase.
// ----------------------------------------------------------------------------
module tb;
  import pdb_pkg::*;

  localparam int NUM_BINS = 8;
  localparam int COORD_W  = 25;
  localparam int SETTLE   = 20;   // outlasts the longest busy stretch of a pair word
  localparam int QUIET_MAX = 400;

  typedef struct {
    logic                      op;
    logic [BINO_W-1:0]         bin_sel;
    logic [EDGE_W-1:0]         low_sq;
    logic [EDGE_W-1:0]         high_sq;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] dz;
    logic [TRACK_W-1:0]        track_a;
    logic [TRACK_W-1:0]        track_b;
    logic [FRAME_W-1:0]        frame;
    logic [FRAME_W-1:0]        end_a;
    logic [FRAME_W-1:0]        end_b;
  } word_t;

  typedef struct {
    logic [BINO_W-1:0]  bin_idx;
    logic [TRACK_W-1:0] track_a;
    logic [TRACK_W-1:0] track_b;
    logic [FRAME_W-1:0] frame;
    logic [LEN_W-1:0]   length;
    logic               last;
  } record_t;

  // Binning predictor and queue of records still owed by the block
  class bin_scoreboard;
    logic [EDGE_W-1:0]  low_sq [NUM_BINS];
    logic [EDGE_W-1:0]  high_sq [NUM_BINS];
    logic [COUNT_W-1:0] hits [NUM_BINS];
    logic               full [NUM_BINS];
    logic [CFG_W-1:0]   min_len;
    logic [CFG_W-1:0]   max_pairs;
    record_t            owed_q[$];
    int                 errors;

    function new();
      foreach (hits[b]) begin
        low_sq[b] = '0;
        high_sq[b] = '0;
        hits[b] = '0;
        full[b] = 1'b0;
      end
      min_len = MIN_LEN_RST;
      max_pairs = MAX_PAIRS_RST;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_MIN_LEN) begin
        min_len = val;
      end else begin
        max_pairs = val;
      end
    endfunction

    function logic [EDGE_W-1:0] square(logic signed [COORD_W-1:0] d);
      logic [COORD_W-1:0] mag;
      // the most negative value negates to itself, which read unsigned is 2^24
      mag = d[COORD_W-1] ? COORD_W'(-d) : COORD_W'(d);
      return EDGE_W'(mag) * EDGE_W'(mag);
    endfunction

    // Note one accepted word and queue the records it causes
    function void note_word(word_t w);
      logic [EDGE_W-1:0]  dist_sq;
      logic [FRAME_W-1:0] end_min;
      int                 len_s;
      record_t            rec;
      record_t            run[$];
      if (w.op == OP_LOAD) begin
        low_sq[w.bin_sel] = w.low_sq;
        high_sq[w.bin_sel] = w.high_sq;
        return;
      end
      dist_sq = square(w.dx) + square(w.dy) + square(w.dz);
      if (dist_sq > high_sq[NUM_BINS-1]) return;
      end_min = (w.end_a < w.end_b) ? w.end_a : w.end_b;
      len_s = int'(end_min) - int'(w.frame) + 1;
      // walk bins upward, stop at a full bin or a lower edge above the distance
      for (int b = 0; b < NUM_BINS; b++) begin
        if (full[b] || dist_sq < low_sq[b]) break;
        if (dist_sq > high_sq[b]) continue;
        if (len_s <= int'(min_len)) continue;
        rec.bin_idx = BINO_W'(b);
        rec.track_a = w.track_a;
        rec.track_b = w.track_b;
        rec.frame = w.frame;
        rec.length = LEN_W'(len_s);
        rec.last = 1'b0;
        run.insert(run.size(), rec);
        if (hits[b] != '1) hits[b]++;
        if (hits[b] > COUNT_W'(max_pairs)) full[b] = 1'b1;
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) owed_q.insert(owed_q.size(), run[i]);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Check one emitted record against the oldest owed one
    function void check_record(record_t got);
      record_t want;
      if (owed_q.size() == 0) begin
        $error("bin_index: expected no record, got %0d", got.bin_idx);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      compare("bin_index", 64'(want.bin_idx), 64'(got.bin_idx));
      compare("out_track_a", 64'(want.track_a), 64'(got.track_a));
      compare("out_track_b", 64'(want.track_b), 64'(got.track_b));
      compare("out_frame", 64'(want.frame), 64'(got.frame));
      compare("pair_length", 64'(want.length), 64'(got.length));
      compare("last_of_run", 64'(want.last), 64'(got.last));
    endfunction

    function int owed();
      return owed_q.size();
    endfunction

    function void check_drained();
      if (owed_q.size() != 0) begin
        $error("records owed at end: expected 0, got %0d", owed_q.size());
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      op_i = OP_LOAD;
  logic [BINO_W-1:0]         bin_select_i = '0;
  logic [EDGE_W-1:0]         edge_low_sq_i = '0;
  logic [EDGE_W-1:0]         edge_high_sq_i = '0;
  logic signed [COORD_W-1:0] delta_x_i = '0;
  logic signed [COORD_W-1:0] delta_y_i = '0;
  logic signed [COORD_W-1:0] delta_z_i = '0;
  logic [TRACK_W-1:0]        track_a_i = '0;
  logic [TRACK_W-1:0]        track_b_i = '0;
  logic [FRAME_W-1:0]        frame_number_i = '0;
  logic [FRAME_W-1:0]        end_frame_a_i = '0;
  logic [FRAME_W-1:0]        end_frame_b_i = '0;
  logic                      result_valid_o;
  logic [BINO_W-1:0]         bin_index_o;
  logic [TRACK_W-1:0]        out_track_a_o;
  logic [TRACK_W-1:0]        out_track_b_o;
  logic [FRAME_W-1:0]        out_frame_o;
  logic [LEN_W-1:0]          pair_length_o;
  logic                      last_of_run_o;
  logic                      cfg_we_i = 1'b0;
  logic                      cfg_idx_i = CFG_MIN_LEN;
  logic [CFG_W-1:0]          cfg_wdata_i = '0;

  bin_scoreboard sb = new();
  int            idle_pct = 26;

  pair_distance_binner #(
    .NUM_BINS  (NUM_BINS),
    .COORD_BITS(COORD_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .bin_select_i  (bin_select_i),
    .edge_low_sq_i (edge_low_sq_i),
    .edge_high_sq_i(edge_high_sq_i),
    .delta_x_i     (delta_x_i),
    .delta_y_i     (delta_y_i),
    .delta_z_i     (delta_z_i),
    .track_a_i     (track_a_i),
    .track_b_i     (track_b_i),
    .frame_number_i(frame_number_i),
    .end_frame_a_i (end_frame_a_i),
    .end_frame_b_i (end_frame_b_i),
    .result_valid_o(result_valid_o),
    .bin_index_o   (bin_index_o),
    .out_track_a_o (out_track_a_o),
    .out_track_b_o (out_track_b_o),
    .out_frame_o   (out_frame_o),
    .pair_length_o (pair_length_o),
    .last_of_run_o (last_of_run_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Word with every field random
  function automatic word_t noise_word();
    word_t w;
    w.op = 1'($urandom);
    w.bin_sel = BINO_W'($urandom);
    w.low_sq = EDGE_W'({$urandom, $urandom});
    w.high_sq = EDGE_W'({$urandom, $urandom});
    w.dx = COORD_W'($urandom);
    w.dy = COORD_W'($urandom);
    w.dz = COORD_W'($urandom);
    w.track_a = TRACK_W'($urandom);
    w.track_b = TRACK_W'($urandom);
    w.frame = FRAME_W'($urandom);
    w.end_a = FRAME_W'($urandom);
    w.end_b = FRAME_W'($urandom);
    return w;
  endfunction

  function automatic word_t load_word(logic [BINO_W-1:0] sel, logic [EDGE_W-1:0] lo,
                                      logic [EDGE_W-1:0] hi);
    word_t w;
    w = noise_word();
    w.op = OP_LOAD;
    w.bin_sel = sel;
    w.low_sq = lo;
    w.high_sq = hi;
    return w;
  endfunction

  function automatic word_t pair_word(logic signed [COORD_W-1:0] dx,
                                      logic signed [COORD_W-1:0] dy,
                                      logic signed [COORD_W-1:0] dz,
                                      logic [FRAME_W-1:0] frame,
                                      logic [FRAME_W-1:0] end_a,
                                      logic [FRAME_W-1:0] end_b);
    word_t w;
    w = noise_word();
    w.op = OP_PAIR;
    w.dx = dx;
    w.dy = dy;
    w.dz = dz;
    w.frame = frame;
    w.end_a = end_a;
    w.end_b = end_b;
    return w;
  endfunction

  // Delta with magnitude below 2^k, or fully random at the widest scale
  function automatic logic signed [COORD_W-1:0] rand_delta(int k);
    logic [COORD_W-1:0]        mag;
    logic signed [COORD_W-1:0] d;
    if (k >= COORD_W - 1) return COORD_W'($urandom);
    mag = COORD_W'($urandom) & ((COORD_W'(1) << k) - 1'b1);
    d = mag;
    if ($urandom_range(0, 1)) d = -d;
    return d;
  endfunction

  // Random pair: mostly lengths just past the threshold, some at it, ending early or fully random
  function automatic word_t random_pair(logic [CFG_W-1:0] min_len);
    word_t w;
    int    k, r, len, lo, hi, end_min, other;
    w = noise_word();
    w.op = OP_PAIR;
    k = $urandom_range(0, COORD_W - 1);
    w.dx = rand_delta(k);
    w.dy = rand_delta($urandom_range(0, k));
    w.dz = rand_delta($urandom_range(0, k));
    r = $urandom_range(0, 99);
    if (r < 90) begin
      if (r < 70) begin
        len = int'(min_len) + 1 + $urandom_range(0, 400);
        if (len > 65536) len = 65536;
      end else if (r < 80) begin
        len = int'(min_len);
      end else begin
        len = 1 - int'($urandom_range(1, 50));
      end
      lo = (len < 1) ? 1 - len : 0;
      hi = (len < 1) ? 65535 : 65536 - len;
      w.frame = FRAME_W'($urandom_range(hi, lo));
      end_min = int'(w.frame) + len - 1;
      other = $urandom_range(65535, end_min);
      if ($urandom_range(0, 1)) begin
        w.end_a = FRAME_W'(end_min);
        w.end_b = FRAME_W'(other);
      end else begin
        w.end_a = FRAME_W'(other);
        w.end_b = FRAME_W'(end_min);
      end
    end
    return w;
  endfunction

  // Offer one word, hold it until accepted, then maybe drop start for a gap
  task automatic drive_word(word_t w);
    start <= 1'b1;
    op_i <= w.op;
    bin_select_i <= w.bin_sel;
    edge_low_sq_i <= w.low_sq;
    edge_high_sq_i <= w.high_sq;
    delta_x_i <= w.dx;
    delta_y_i <= w.dy;
    delta_z_i <= w.dz;
    track_a_i <= w.track_a;
    track_b_i <= w.track_b;
    frame_number_i <= w.frame;
    end_frame_a_i <= w.end_a;
    end_frame_b_i <= w.end_b;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_word(w);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Load all bins with a rising layout: tiled, overlapping or gapped bins
  task automatic send_layout();
    logic [EDGE_W-1:0] bound [NUM_BINS+1];
    logic [EDGE_W-1:0] lo, hi;
    int                top;
    bound[0] = '0;
    for (int b = 1; b <= NUM_BINS; b++) begin
      bound[b] = EDGE_W'($urandom_range(1, 63)) << (6 * b - 6);
    end
    for (int b = 0; b < NUM_BINS; b++) begin
      lo = bound[b];
      if (b == 0 && $urandom_range(0, 3) == 0) lo = bound[1] >> 1;
      case ($urandom_range(0, 3))
        2: begin
          top = b + 1 + $urandom_range(1, 2);
          if (top > NUM_BINS) top = NUM_BINS;
          hi = bound[top];
        end
        3: begin
          hi = bound[b] + ((bound[b+1] - bound[b]) >> 1);
        end
        default: begin
          hi = bound[b+1] - 1'b1;
        end
      endcase
      if (b == NUM_BINS - 1 && $urandom_range(0, 3) == 0) hi = '1;
      drive_word(load_word(BINO_W'(b), lo, hi));
    end
  endtask

  // Drop start, wait for all owed records, then let an in-flight word finish
  task automatic settle(int extra);
    start <= 1'b0;
    while (sb.owed() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic configure(logic [CFG_W-1:0] min_len, logic [CFG_W-1:0] max_pairs);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MIN_LEN;
    cfg_wdata_i <= min_len;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MAX_PAIRS;
    cfg_wdata_i <= max_pairs;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(CFG_MIN_LEN, min_len);
    sb.write_reg(CFG_MAX_PAIRS, max_pairs);
    @(posedge clk_i);
  endtask

  // One random phase: fresh layout, then pairs with occasional reloads
  task automatic run_phase(int n_words, int gap_pct, logic [CFG_W-1:0] min_len,
                           logic [CFG_W-1:0] max_pairs);
    int sent, r;
    settle(SETTLE);
    configure(min_len, max_pairs);
    idle_pct = gap_pct;
    send_layout();
    sent = NUM_BINS;
    while (sent < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_layout();
        sent += NUM_BINS;
      end else if (r < 8) begin
        drive_word(load_word(BINO_W'($urandom), EDGE_W'({$urandom, $urandom}),
                             EDGE_W'({$urandom, $urandom})));
        sent++;
      end else begin
        drive_word(random_pair(sb.min_len));
        sent++;
      end
    end
  endtask

  // Capture each emitted record
  always @(posedge clk_i) begin : result_tap
    record_t got;
    if (rst_ni === 1'b1 && result_valid_o !== 1'b0) begin
      got.bin_idx = bin_index_o;
      got.track_a = out_track_a_o;
      got.track_b = out_track_b_o;
      got.frame = out_frame_o;
      got.length = pair_length_o;
      got.last = last_of_run_o;
      sb.check_record(got);
    end
  end

  // End the run after too long a stretch with no word moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((start && !busy) || result_valid_o || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("pair_distance_binner verification failed");
    $finish;
  end

  initial begin : main_seq
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every bin spans the whole range: a kept pair lands in all of them
    for (int b = 0; b < NUM_BINS; b++) begin
      drive_word(load_word(BINO_W'(b), '0, '1));
    end
    // most negative deltas, longest possible pair
    drive_word(pair_word(25'h1000000, 25'h1000000, 25'h1000000, 16'd0,
                         16'hFFFF, 16'hFFFF));
    // most positive deltas, length one is dropped
    drive_word(pair_word(25'h0FFFFFF, 25'h0FFFFFF, 25'h0FFFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF));
    // pair ends before its frame
    drive_word(pair_word(25'd3, 25'd4, 25'd5, 16'd500, 16'd400, 16'd900));
    // length equal to the threshold is dropped, one more is kept
    drive_word(pair_word(25'd7, -25'd7, 25'd0, 16'd1000, 16'd1099, 16'd2000));
    drive_word(pair_word(-25'd9, 25'd2, 25'd1, 16'd1000, 16'd3000, 16'd1100));

    // Tiled bins sharing their boundaries: [1000 b, 1000 (b + 1)]
    for (int b = 0; b < NUM_BINS; b++) begin
      drive_word(load_word(BINO_W'(b), EDGE_W'(1000 * b), EDGE_W'(1000 * (b + 1))));
    end
    // distance on a shared boundary falls in both bins
    drive_word(pair_word(25'd60, 25'd20, 25'd0, 16'd10, 16'd500, 16'd600));
    // just beyond the last bin
    drive_word(pair_word(25'd89, 25'd8, 25'd4, 16'd10, 16'd500, 16'd600));
    // top edge of the last bin
    drive_word(pair_word(-25'd80, 25'd40, 25'd0, 16'd20, 16'd900, 16'd300));
    // zero distance
    drive_word(pair_word(25'd0, 25'd0, 25'd0, 16'd30, 16'd800, 16'd200));

    run_phase(110, 26, 16'd0, 16'hFFFF);
    run_phase(110, 26, CFG_W'($urandom_range(1, 300)), 16'd50000);
    run_phase(30, 71, 16'hFFFF, 16'hFFFF);
    run_phase(100, 71, CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(1000, 65535)));
    // small limits fill the bins and cut the walk short
    run_phase(50, 0, 16'd0, CFG_W'($urandom_range(2, 6)));
    run_phase(30, 0, 16'd0, 16'd0);

    settle(SETTLE + 10);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("pair_distance_binner verification clean");
    end else begin
      $display("pair_distance_binner verification failed");
    end
    $finish;
  end

endmodule
